[hw/rtl/hcr_pkg.sv]
// ----------------------------------------------------------------------------
// hcr_pkg: shared types and constants of the height to color ramp
// palette colors, register indexes and the sideband flags of the divider
// ----------------------------------------------------------------------------
`default_nettype none

package hcr_pkg;

    // register index taken from paddr[2]
    localparam logic REG_HEIGHT_MIN = 1'b0;
    localparam logic REG_HEIGHT_MAX = 1'b1;

    localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;

    // per-item flags that ride along the divider chain
    typedef struct packed {
        logic white;   // equal limits
        logic cool;    // below the midpoint of the range
        logic sat;     // magnitude one or more
    } flags_t;

    // palette lookup, warm or cool, index 0 (white) to 4 (last color)
    function automatic logic [23:0] palette_color(input logic cool, input logic [2:0] idx);
        logic [23:0] c;
        c = RGB_WHITE;
        if (cool) begin
            unique case (idx)
                3'd0:    c = 24'hFFFFFF;
                3'd1:    c = 24'h00FF00;
                3'd2:    c = 24'h00FFFF;
                3'd3:    c = 24'h0000FF;
                default: c = 24'h00008B;
            endcase
        end else begin
            unique case (idx)
                3'd0:    c = 24'hFFFFFF;
                3'd1:    c = 24'hFFFF00;
                3'd2:    c = 24'hFFA500;
                3'd3:    c = 24'hFF0000;
                default: c = 24'h8B00FF;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hcr_prep.sv]
// ----------------------------------------------------------------------------
// hcr_prep: normalization front end
// three registered stages: offsets, scaled numerator, magnitude and flags
// ----------------------------------------------------------------------------
`default_nettype none

module hcr_prep #(
    parameter int H = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [H-1:0]         height,
    input  wire logic [H-1:0]         height_min,
    input  wire logic [H-1:0]         height_max,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [H-1:0]              out_rem,
    output logic [H-1:0]              out_div,
    output logic [1:0]                out_feed,
    output hcr_pkg::flags_t           out_flags
);

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    // stage 1 data
    logic [H:0] d1_reg, d1_next;
    logic [H:0] w1_reg, w1_next;

    // stage 2 data
    logic [H+4:0] num2_reg, num2_next;
    logic [H-1:0] aw2_reg, aw2_next;
    logic         wneg2_reg;
    logic         white2_reg;
    logic [H:0]   w_abs;

    // stage 3 data
    logic [H+3:0]    anum;
    logic [H+4:0]    num_neg;
    logic [H-1:0]    rem3_reg;
    logic [H-1:0]    div3_reg;
    logic [1:0]      feed3_reg;
    hcr_pkg::flags_t flags3_reg, flags3_next;

    // ready chain, a stage takes a beat when empty or draining
    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    // offsets from the lower limit
    assign d1_next = {height[H-1], height} - {height_min[H-1], height_min};
    assign w1_next = {height_max[H-1], height_max} - {height_min[H-1], height_min};

    // numerator 8*d - 4*w and width magnitude
    assign num2_next = {d1_reg[H], d1_reg, 3'b000} - {w1_reg[H], w1_reg[H], w1_reg, 2'b00};
    assign w_abs     = w1_reg[H] ? ((~w1_reg) + {{H{1'b0}}, 1'b1}) : w1_reg;
    assign aw2_next  = w_abs[H-1:0];

    // numerator magnitude, palette side and saturation
    assign num_neg               = (~num2_reg) + {{(H+4){1'b0}}, 1'b1};
    assign anum                  = num2_reg[H+4] ? num_neg[H+3:0] : num2_reg[H+3:0];
    assign flags3_next.white     = white2_reg;
    assign flags3_next.cool      = (num2_reg != '0) && (num2_reg[H+4] != wneg2_reg);
    assign flags3_next.sat       = anum >= {2'b00, aw2_reg, 2'b00};

    always_ff @(posedge aclk) begin
        if (in_valid && r1) begin
            d1_reg <= d1_next;
            w1_reg <= w1_next;
        end
        if (v1_reg && r2) begin
            num2_reg   <= num2_next;
            aw2_reg    <= aw2_next;
            wneg2_reg  <= w1_reg[H];
            white2_reg <= (w1_reg == '0);
        end
        if (v2_reg && r3) begin
            rem3_reg   <= anum[H+1:2];
            feed3_reg  <= anum[1:0];
            div3_reg   <= aw2_reg;
            flags3_reg <= flags3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_rem   = rem3_reg;
    assign out_div   = div3_reg;
    assign out_feed  = feed3_reg;
    assign out_flags = flags3_reg;

endmodule

`default_nettype wire

[hw/rtl/hcr_div_cell.sv]
// ----------------------------------------------------------------------------
// hcr_div_cell: one restoring division step
// shifts one numerator bit into the remainder and yields one quotient bit
// ----------------------------------------------------------------------------
`default_nettype none

module hcr_div_cell #(
    parameter int H = 16,
    parameter int Q = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [H-1:0]         in_rem,
    input  wire logic [H-1:0]         in_div,
    input  wire logic [1:0]           in_feed,
    input  wire logic [Q-1:0]         in_quo,
    input  wire hcr_pkg::flags_t      in_flags,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [H-1:0]              out_rem,
    output logic [H-1:0]              out_div,
    output logic [1:0]                out_feed,
    output logic [Q-1:0]              out_quo,
    output hcr_pkg::flags_t           out_flags
);

    logic            valid_reg;
    logic [H-1:0]    rem_reg, rem_next;
    logic [H-1:0]    div_reg;
    logic [1:0]      feed_reg, feed_next;
    logic [Q-1:0]    quo_reg, quo_next;
    hcr_pkg::flags_t flags_reg;
    logic [H:0]      trial;
    logic [H:0]      diff;
    logic            ge;

    assign in_ready = !valid_reg || out_ready;

    // compare and subtract on the shifted remainder
    assign trial     = {in_rem, in_feed[1]};
    assign diff      = trial - {1'b0, in_div};
    assign ge        = trial >= {1'b0, in_div};
    assign rem_next  = ge ? diff[H-1:0] : trial[H-1:0];
    assign quo_next  = {in_quo[Q-2:0], ge};
    assign feed_next = {in_feed[0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rem_reg   <= rem_next;
            div_reg   <= in_div;
            feed_reg  <= feed_next;
            quo_reg   <= quo_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_feed  = feed_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

[hw/rtl/hcr_blend.sv]
// ----------------------------------------------------------------------------
// hcr_blend: palette lookup and channel interpolation
// registered output stage that drives the result stream
// ----------------------------------------------------------------------------
`default_nettype none

module hcr_blend #(
    parameter int F = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [F+1:0]         in_quo,
    input  wire hcr_pkg::flags_t      in_flags,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [23:0]               out_rgb
);

    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic         valid_reg;
    logic [23:0]  rgb_reg, rgb_next;
    logic [2:0]   seg;
    logic [F-1:0] frac;
    logic [F:0]   omf;
    logic [23:0]  c1, c2;
    logic [23:0]  mix;
    logic [F+8:0] sum [3];

    assign in_ready = !valid_reg || out_ready;

    // segment end colors
    assign seg  = {1'b0, in_quo[F+1:F]};
    assign frac = in_quo[F-1:0];
    assign omf  = ONE - {1'b0, frac};
    assign c1   = hcr_pkg::palette_color(in_flags.cool, seg);
    assign c2   = hcr_pkg::palette_color(in_flags.cool, seg + 3'd1);

    // per channel weighted blend, truncated
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = (F+9)'(c1[8*k +: 8]) * (F+9)'(omf)
                   + (F+9)'(c2[8*k +: 8]) * (F+9)'(frac);
            mix[8*k +: 8] = sum[k][F +: 8];
        end
    end

    // special colors take precedence over the blend
    always_comb begin
        priority if (in_flags.white) begin
            rgb_next = hcr_pkg::RGB_WHITE;
        end else if (in_flags.sat) begin
            rgb_next = hcr_pkg::palette_color(in_flags.cool, 3'd4);
        end else begin
            rgb_next = mix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rgb   = rgb_reg;

endmodule

`default_nettype wire

[hw/rtl/height_to_color_ramp_unit.sv]
// ----------------------------------------------------------------------------
// height_to_color_ramp_unit: diverging piecewise-linear color map
// maps a signed height beat to a 24-bit rgb beat over configured limits
// ----------------------------------------------------------------------------
// One rgb beat leaves for every height beat, in order, and a new height beat
// is taken every clock cycle without backpressure. A beat passes three
// normalization stages, a chain of FRAC_BITS + 2 division cells that each
// produce one quotient bit of the magnitude, and one blend stage that is also
// the output register. Every stage holds its beat under backpressure and
// frees itself as soon as the stage after it moves, so bubbles in the chain
// are filled while a result waits at the output. Limits are written over the
// APB port at byte address 0 (minimum) and 4 (maximum); change them only
// while no beat is in flight. Equal limits give white.
`default_nettype none

module height_to_color_ramp_unit #(
    parameter int HEIGHT_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // height input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [((HEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,  // height
    // color output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [23:0]               m_axis_tdata,  // rgb
    // register port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int H = HEIGHT_BITS;
    localparam int Q = FRAC_BITS + 2;

    logic [H-1:0] height_min_reg;
    logic [H-1:0] height_max_reg;
    logic         cfg_write;

    // chain links, index i feeds cell i
    logic            valid_w [Q+1];
    logic            ready_w [Q+1];
    logic [H-1:0]    rem_w   [Q+1];
    logic [H-1:0]    div_w   [Q+1];
    logic [1:0]      feed_w  [Q+1];
    logic [Q-1:0]    quo_w   [Q+1];
    hcr_pkg::flags_t flags_w [Q+1];

    // register writes and reads
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_min_reg <= '0;
            height_max_reg <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                hcr_pkg::REG_HEIGHT_MIN: height_min_reg <= pwdata[H-1:0];
                hcr_pkg::REG_HEIGHT_MAX: height_max_reg <= pwdata[H-1:0];
                default:                 height_min_reg <= height_min_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            hcr_pkg::REG_HEIGHT_MIN: prdata = 32'(height_min_reg);
            hcr_pkg::REG_HEIGHT_MAX: prdata = 32'(height_max_reg);
            default:                 prdata = '0;
        endcase
    end

    // normalization front end
    hcr_prep #(
        .H (H)
    ) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .height     (s_axis_tdata[H-1:0]),
        .height_min (height_min_reg),
        .height_max (height_max_reg),
        .out_valid  (valid_w[0]),
        .out_ready  (ready_w[0]),
        .out_rem    (rem_w[0]),
        .out_div    (div_w[0]),
        .out_feed   (feed_w[0]),
        .out_flags  (flags_w[0])
    );

    assign quo_w[0] = '0;

    // division chain, one quotient bit per cell
    for (genvar i = 0; i < Q; i++) begin : g_cell
        hcr_div_cell #(
            .H (H),
            .Q (Q)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_rem    (rem_w[i]),
            .in_div    (div_w[i]),
            .in_feed   (feed_w[i]),
            .in_quo    (quo_w[i]),
            .in_flags  (flags_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_div   (div_w[i+1]),
            .out_feed  (feed_w[i+1]),
            .out_quo   (quo_w[i+1]),
            .out_flags (flags_w[i+1])
        );
    end

    // blend and output register
    hcr_blend #(
        .F (FRAC_BITS)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_w[Q]),
        .in_ready  (ready_w[Q]),
        .in_quo    (quo_w[Q]),
        .in_flags  (flags_w[Q]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rgb   (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // an empty output stage must leave the whole chain open to input
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output stage");

    // the division leaves a remainder below the divisor
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_w[Q] && !flags_w[Q].sat && !flags_w[Q].white |-> rem_w[Q] < div_w[Q])
        else $error("division remainder out of range");

    // equal limits come out white
    a_white_out: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_w[Q] && ready_w[Q] && flags_w[Q].white |=> m_axis_tdata == hcr_pkg::RGB_WHITE)
        else $error("equal limits did not give white");

    // a beat entering the blend stage shows up at the output next cycle
    a_blend_load: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_w[Q] && ready_w[Q] |=> m_axis_tvalid)
        else $error("blend stage lost a beat");
`endif

endmodule

`default_nettype wire

[sim/height_to_color_ramp_unit_test.sv]
// ----------------------------------------------------------------------------
// height_to_color_ramp_unit_test: self-checking bench for the color ramp
// streams height beats through the unit under random source gaps and sink
// stalls, predicts each rgb beat from the programmed limits and checks the
// output stream in order; limits change only between drained phases
// ----------------------------------------------------------------------------

module height_to_color_ramp_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = 8;
    localparam int LATENCY     = FRAC_BITS + 6;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic [15:0] height;
        logic [23:0] rgb;
    } color_check_t;

    typedef enum int {
        SINK_OPEN,
        SINK_HALF,
        SINK_SPARSE
    } sink_mode_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // height
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [23:0] m_axis_tdata;           // rgb
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    wire  [31:0] prdata;
    wire         pready;

    // bench copy of the limit registers
    logic signed [15:0] cfg_min = '0;
    logic signed [15:0] cfg_max = '0;

    logic [15:0]  height_queue[$];
    color_check_t color_queue[$];
    color_check_t new_check;
    color_check_t old_check;

    int         error_count = 0;
    int         cycle_count = 0;
    int         burst_left  = 0;
    int         gap_left    = 0;
    int         sink_left   = 0;
    sink_mode_t sink_mode   = SINK_OPEN;

    height_to_color_ramp_unit #(
        .HEIGHT_BITS(16),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // color stops of both palettes, 0 is white and 4 the far end
    function automatic logic [23:0] ramp_stop(input logic cool, input int idx);
        logic [23:0] c;
        c = 24'hFFFFFF;
        if (cool) begin
            case (idx)
                1:       c = 24'h00FF00;
                2:       c = 24'h00FFFF;
                3:       c = 24'h0000FF;
                4:       c = 24'h00008B;
                default: c = 24'hFFFFFF;
            endcase
        end else begin
            case (idx)
                1:       c = 24'hFFFF00;
                2:       c = 24'hFFA500;
                3:       c = 24'hFF0000;
                4:       c = 24'h8B00FF;
                default: c = 24'hFFFFFF;
            endcase
        end
        return c;
    endfunction

    // expected color of one height under the given limits
    function automatic logic [23:0] ramp_color(input logic signed [15:0] z,
                                               input logic signed [15:0] lo,
                                               input logic signed [15:0] hi);
        longint      span;
        longint      num;
        longint      anum;
        longint      aspan;
        longint      mag;
        int          seg;
        int          frac;
        int          a;
        int          b;
        logic        cool;
        logic [23:0] c_lo;
        logic [23:0] c_hi;
        logic [23:0] mix;
        span = longint'(hi) - longint'(lo);
        if (span == 0)
            return hcr_pkg::RGB_WHITE;
        num   = 8 * (longint'(z) - longint'(lo)) - 4 * span;
        cool  = (num != 0) && ((num < 0) != (span < 0));
        anum  = (num < 0) ? -num : num;
        aspan = (span < 0) ? -span : span;
        mag   = (anum << FRAC_BITS) / aspan;
        seg   = int'(mag >> FRAC_BITS);
        frac  = int'(mag & ((64'd1 << FRAC_BITS) - 1));
        if (seg >= 4)
            return ramp_stop(cool, 4);
        c_lo = ramp_stop(cool, seg);
        c_hi = ramp_stop(cool, seg + 1);
        mix  = '0;
        for (int ch = 0; ch < 3; ch++) begin
            a = c_lo[8*ch +: 8];
            b = c_hi[8*ch +: 8];
            mix[8*ch +: 8] = 8'((a * ((1 << FRAC_BITS) - frac) + b * frac) >> FRAC_BITS);
        end
        return mix;
    endfunction

    // height source: bursts and gaps, prediction taken at each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                new_check.height = s_axis_tdata;
                new_check.rgb    = ramp_color(s_axis_tdata, cfg_min, cfg_max);
                color_queue.push_back(new_check);
                void'(height_queue.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (height_queue.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= height_queue[0];
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(64, 200)
                                                                 : $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // rgb sink: stall pattern switches between open, half and sparse stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_mode <= sink_mode_t'($urandom_range(0, 2));
                sink_left <= $urandom_range(20, 150);
            end else begin
                sink_left <= sink_left - 1;
            end
            case (sink_mode)
                SINK_OPEN: m_axis_tready <= 1'b1;
                SINK_HALF: m_axis_tready <= 1'($urandom_range(0, 1));
                default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // rgb check against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (color_queue.size() == 0) begin
                error_count <= error_count + 1;
                $display("%0t: rgb beat %06h arrived with nothing expected",
                         $time, m_axis_tdata);
            end else begin
                old_check = color_queue.pop_front();
                if (m_axis_tdata !== old_check.rgb) begin
                    error_count <= error_count + 1;
                    $display("%0t: rgb mismatch for height %0d: expected %06h, actual %06h",
                             $time, $signed(old_check.height), old_check.rgb, m_axis_tdata);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // register write: setup then access
    task automatic write_limit(input logic idx, input logic signed [15:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{16{value[15]}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == hcr_pkg::REG_HEIGHT_MIN)
            cfg_min = value;
        else
            cfg_max = value;
    endtask

    task automatic set_limits(input logic signed [15:0] lo, input logic signed [15:0] hi);
        write_limit(hcr_pkg::REG_HEIGHT_MIN, lo);
        write_limit(hcr_pkg::REG_HEIGHT_MAX, hi);
    endtask

    // wait for every queued beat to come back, then let the pipe settle
    task automatic drain();
        while (height_queue.size() != 0 || color_queue.size() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // random heights: mostly inside the range, some around the edges, some anywhere
    task automatic queue_random(input int count);
        int a;
        int b;
        int h;
        int pick;
        a = (cfg_min < cfg_max) ? cfg_min : cfg_max;
        b = (cfg_min < cfg_max) ? cfg_max : cfg_min;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
                h = a + int'($urandom_range(0, b - a));
            else if (pick == 8)
                h = ($urandom_range(0, 1) ? a : b) + int'($urandom_range(0, 6)) - 3;
            else
                h = int'($urandom());
            height_queue.push_back(h[15:0]);
        end
    endtask

    // limits for one random phase, extremes included
    task automatic pick_limits();
        int kind;
        int lo;
        int hi;
        logic [15:0] r;
        kind = $urandom_range(0, 9);
        r    = 16'($urandom());
        lo   = int'($signed(r));
        r    = 16'($urandom());
        hi   = int'($signed(r));
        case (kind)
            0: begin lo = -32768; hi = 32767;  end
            1: begin lo = 32767;  hi = -32768; end
            2: hi = lo;
            3: begin
                hi = lo + int'($urandom_range(1, 16));
                if (hi > 32767)
                    hi = lo - int'($urandom_range(1, 16));
            end
            default: ;
        endcase
        set_limits(16'(lo), 16'(hi));
    endtask

    // stimulus
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // limits still at reset, equal, so white everywhere
        height_queue.push_back(16'h8000);
        height_queue.push_back(16'h7FFF);
        height_queue.push_back(16'h0000);
        drain();

        // full range: both ends, midpoint and quarter points
        set_limits(-16'sd32768, 16'sd32767);
        height_queue.push_back(16'h8000);
        height_queue.push_back(16'h7FFF);
        height_queue.push_back(16'hFFFF);
        height_queue.push_back(16'h0000);
        height_queue.push_back(16'd16383);
        height_queue.push_back(-16'sd16384);
        height_queue.push_back(16'd24575);
        drain();

        // reversed limits mirror the ramp
        set_limits(16'sd32767, -16'sd32768);
        height_queue.push_back(16'h8000);
        height_queue.push_back(16'h7FFF);
        height_queue.push_back(16'h0000);
        height_queue.push_back(16'd8192);
        drain();

        // narrow range: exact midpoint, segment edges and heights outside
        set_limits(-16'sd4, 16'sd4);
        height_queue.push_back(16'h8000);
        height_queue.push_back(-16'sd5);
        height_queue.push_back(-16'sd4);
        height_queue.push_back(-16'sd2);
        height_queue.push_back(16'd0);
        height_queue.push_back(16'd2);
        height_queue.push_back(16'd4);
        height_queue.push_back(16'd5);
        height_queue.push_back(16'h7FFF);
        drain();

        // equal nonzero limits
        set_limits(16'sd1234, 16'sd1234);
        height_queue.push_back(16'd1234);
        height_queue.push_back(16'h8000);
        drain();

        // random phases
        for (int p = 0; p < 10; p++) begin
            pick_limits();
            queue_random(95);
            drain();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
